// File: hdl/gb3_pkg.sv
// shared types and constants of the 3x3 gaussian blur
`timescale 1ns / 1ps
package gb3_pkg;

	localparam int PIX_W     = 8;
	localparam int FW_W      = 11;
	localparam int FH_W      = 12;
	localparam int WGT_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	localparam logic [FW_W-1:0]  FRAME_WIDTH_RST   = 11'd64;
	localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST  = 12'd64;
	localparam logic [WGT_W-1:0] WEIGHT_CENTER_RST = 16'd21752;
	localparam logic [WGT_W-1:0] WEIGHT_EDGE_RST   = 16'd8001;
	localparam logic [WGT_W-1:0] WEIGHT_CORNER_RST = 16'd2945;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_WEIGHT_CENTER = 3'd2,
		REG_WEIGHT_EDGE   = 3'd3,
		REG_WEIGHT_CORNER = 3'd4
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;
	// rows top..bottom of one window column
	typedef logic [2:0][PIX_W-1:0] col_t;

endpackage

// File: hdl/gb3_stream_if.sv
// valid/ready stream interfaces for pixel beats and result beats
`timescale 1ns / 1ps
interface gb3_in_if import gb3_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output cmd, output pixel_in, input ready);
	modport sink (input valid, input cmd, input pixel_in, output ready);
endinterface

interface gb3_out_if import gb3_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [PIX_W-1:0] pixel_out;
	logic       last_of_frame;

	modport source (output valid, output pixel_out, output last_of_frame, input ready);
	modport sink (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

// File: hdl/gb3_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module gb3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/gaussian_blur_3x3_clamped_edges.sv
// 3x3 gaussian blur with replicated borders over a raster pixel stream
// throughput: one beat per clock while ready is high; one line ram read and write per beat
// a result is summed, weighted and queued after the beat that completes its window,
//   which is the beat one row plus one pixel after the pixel itself
// the ram is read at accept, written back next cycle; back-to-back hits are forwarded
// reset: async active low; config returns to defaults, counters clear, line ram is not cleared
`timescale 1ns / 1ps
module gaussian_blur_3x3_clamped_edges import gb3_pkg::*; #(
	parameter int MAX_WIDTH        = 1024,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gb3_in_if.sink               pixels,
	gb3_out_if.source            results,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int AW         = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
	localparam int LINE_W     = 2 * PIX_W;
	localparam int SUM4_W     = PIX_W + 2;
	localparam int PC_W       = WGT_W + PIX_W;
	localparam int PE_W       = WGT_W + SUM4_W;
	localparam int ACC_W      = PE_W + 2;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;
	localparam int BUSY_W     = FIFO_AW + 2;

	// configuration
	logic [FW_W-1:0]  width_m1_q;
	logic [FH_W-1:0]  height_q, height_m1_q;
	logic [WGT_W-1:0] w_ctr_q, w_edg_q, w_cor_q;
	logic             size_wr;

	assign size_wr = cfg_we && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_m1_q  <= FRAME_WIDTH_RST - 1'b1;
			height_q    <= FRAME_HEIGHT_RST;
			height_m1_q <= FRAME_HEIGHT_RST - 1'b1;
			w_ctr_q     <= WEIGHT_CENTER_RST;
			w_edg_q     <= WEIGHT_EDGE_RST;
			w_cor_q     <= WEIGHT_CORNER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					if (cfg_data[FW_W-1:0] == '0) begin
						width_m1_q <= '0;
					end else if (32'(cfg_data[FW_W-1:0]) > MAX_WIDTH) begin
						width_m1_q <= FW_W'(MAX_WIDTH - 1);
					end else begin
						width_m1_q <= cfg_data[FW_W-1:0] - 1'b1;
					end
				end
				REG_FRAME_HEIGHT: begin
					if (cfg_data[FH_W-1:0] == '0) begin
						height_q    <= FH_W'(1);
						height_m1_q <= '0;
					end else begin
						height_q    <= cfg_data[FH_W-1:0];
						height_m1_q <= cfg_data[FH_W-1:0] - 1'b1;
					end
				end
				REG_WEIGHT_CENTER: w_ctr_q <= cfg_data[WGT_W-1:0];
				REG_WEIGHT_EDGE:   w_edg_q <= cfg_data[WGT_W-1:0];
				REG_WEIGHT_CORNER: w_cor_q <= cfg_data[WGT_W-1:0];
				default: ;
			endcase
		end
	end

	// frame position counters
	logic [AW-1:0]   in_col_q, out_col_q;
	logic [FH_W:0]   in_row_q;
	logic [FH_W-1:0] out_row_q;

	logic take, is_drain, frame_full, active;
	logic col_wrap, emit, oc_wrap, or_last, last;
	pix_t pix_new;

	assign take       = pixels.valid && pixels.ready;
	assign is_drain   = pixels.cmd == CMD_DRAIN;
	assign frame_full = in_row_q >= {1'b0, height_q};
	// pixels before frame end, drains after it; everything else is dropped
	assign active     = take && (is_drain == frame_full);
	assign pix_new    = is_drain ? '0 : pixels.pixel_in;

	assign col_wrap = 32'(in_col_q) == 32'(width_m1_q);
	assign emit     = (in_row_q >= (FH_W+1)'(2)) || (in_row_q == (FH_W+1)'(1) && in_col_q != '0);
	assign oc_wrap  = 32'(out_col_q) == 32'(width_m1_q);
	assign or_last  = out_row_q == height_m1_q;
	assign last     = emit && oc_wrap && or_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (size_wr || (active && last)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (active) begin
			in_col_q <= col_wrap ? '0 : in_col_q + 1'b1;
			in_row_q <= in_row_q + (FH_W+1)'(col_wrap);
			if (emit) begin
				out_col_q <= oc_wrap ? '0 : out_col_q + 1'b1;
				out_row_q <= out_row_q + FH_W'(oc_wrap);
			end
		end
	end

	// stage 1: line ram data returns, window shifts, ram write-back
	logic             v_s1, emit_s1, lsel_s1, rsel_s1, top_s1, bot_s1, last_s1, fwd_s1;
	logic [AW-1:0]    addr_s1;
	pix_t             pix_s1;
	logic [LINE_W-1:0] fwd_data_s1;
	logic [LINE_W-1:0] ram_rdata, line_word, wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= active;
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			addr_s1     <= in_col_q;
			pix_s1      <= pix_new;
			emit_s1     <= emit;
			lsel_s1     <= out_col_q == '0;
			rsel_s1     <= oc_wrap;
			top_s1      <= out_row_q == '0;
			bot_s1      <= or_last;
			last_s1     <= last;
			// the write of the item ahead lands on the same edge as this read
			fwd_s1      <= v_s1 && (addr_s1 == in_col_q);
			fwd_data_s1 <= wr_data;
		end
	end

	gb3_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (v_s1),
		.waddr(addr_s1),
		.wdata(wr_data),
		.re   (active),
		.raddr(in_col_q),
		.rdata(ram_rdata)
	);

	// upper byte: two rows back, lower byte: one row back
	assign line_word = fwd_s1 ? fwd_data_s1 : ram_rdata;
	assign wr_data   = {line_word[PIX_W-1:0], pix_s1};

	col_t col_a_q, col_b_q;
	col_t col_new, col_l, col_c, col_r;

	assign col_new = {pix_s1, line_word[PIX_W-1:0], line_word[LINE_W-1:PIX_W]};
	assign col_c   = col_b_q;
	assign col_l   = lsel_s1 ? col_b_q : col_a_q;
	assign col_r   = rsel_s1 ? col_b_q : col_new;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			col_a_q <= col_b_q;
			col_b_q <= col_new;
		end
	end

	function automatic pix_t pick_top(input col_t c, input logic top);
		return top ? c[1] : c[0];
	endfunction

	function automatic pix_t pick_bot(input col_t c, input logic bot);
		return bot ? c[1] : c[2];
	endfunction

	logic [SUM4_W-1:0] edg_sum, cor_sum;

	assign edg_sum = SUM4_W'(pick_top(col_c, top_s1)) + SUM4_W'(pick_bot(col_c, bot_s1))
		+ SUM4_W'(col_l[1]) + SUM4_W'(col_r[1]);
	assign cor_sum = SUM4_W'(pick_top(col_l, top_s1)) + SUM4_W'(pick_bot(col_l, bot_s1))
		+ SUM4_W'(pick_top(col_r, top_s1)) + SUM4_W'(pick_bot(col_r, bot_s1));

	// stage 2: tap sums
	logic              v_s2, last_s2;
	pix_t              ctr_s2;
	logic [SUM4_W-1:0] edg_s2, cor_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctr_s2  <= col_c[1];
		edg_s2  <= edg_sum;
		cor_s2  <= cor_sum;
		last_s2 <= last_s1;
	end

	// stage 3: weighted products
	logic            v_s3, last_s3;
	logic [PC_W-1:0] prod_c_s3;
	logic [PE_W-1:0] prod_e_s3, prod_k_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_c_s3 <= PC_W'(w_ctr_q) * PC_W'(ctr_s2);
		prod_e_s3 <= PE_W'(w_edg_q) * PE_W'(edg_s2);
		prod_k_s3 <= PE_W'(w_cor_q) * PE_W'(cor_s2);
		last_s3   <= last_s2;
	end

	logic [ACC_W-1:0] acc, acc_sh;
	pix_t             res_pix;

	assign acc     = ACC_W'(prod_c_s3) + ACC_W'(prod_e_s3) + ACC_W'(prod_k_s3);
	assign acc_sh  = acc >> WEIGHT_FRAC_BITS;
	assign res_pix = (acc_sh > ACC_W'(PIX_MAX)) ? PIX_MAX : acc_sh[PIX_W-1:0];

	// result fifo; input ready reserves a slot for every beat in flight
	pix_t               fifo_pix_q  [FIFO_DEPTH];
	logic               fifo_last_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               pop;
	logic [BUSY_W-1:0]  busy;

	assign pop  = results.valid && results.ready;
	assign busy = BUSY_W'(count_q) + BUSY_W'(v_s1) + BUSY_W'(v_s2) + BUSY_W'(v_s3);

	assign pixels.ready          = busy < BUSY_W'(FIFO_DEPTH);
	assign results.valid         = count_q != '0;
	assign results.pixel_out     = fifo_pix_q[rd_ptr_q];
	assign results.last_of_frame = fifo_last_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (v_s3) begin
			fifo_pix_q[wr_ptr_q]  <= res_pix;
			fifo_last_q[wr_ptr_q] <= last_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (v_s3) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (FIFO_AW+1)'(v_s3) - (FIFO_AW+1)'(pop);
		end
	end

endmodule

// File: dv/gaussian_blur_3x3_clamped_edges_tb.sv
// self-checking testbench of the 3x3 gaussian blur with replicated borders
`timescale 1ns / 1ps
module gaussian_blur_3x3_clamped_edges_tb;
	import gb3_pkg::*;

	localparam int          MAXW           = 1024;
	localparam int          FRAC           = 16;
	localparam int          DRAIN_LAT      = 8;
	localparam int          RANDOM_BEATS   = 600;
	localparam int unsigned WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		cmd_t cmd;
		pix_t pix;
	} pix_beat_t;

	typedef struct packed {
		pix_t pixel_out;
		logic last_of_frame;
	} blur_res_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	gb3_in_if  pix_if ();
	gb3_out_if res_if ();

	gaussian_blur_3x3_clamped_edges u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pix_if),
		.results   (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pix_beat_t   pixel_beats_q[$];
	blur_res_t   blurred_q[$];
	pix_beat_t   drv_beat;
	blur_res_t   want;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned send_idle_pct  = 14;
	int unsigned recv_idle_pct  = 66;
	int unsigned random_beats   = 0;

	// shadow of the block: registers, line stores, window, counters
	logic [FW_W-1:0]  frame_w_reg;
	logic [FH_W-1:0]  frame_h_reg;
	logic [WGT_W-1:0] wgt_center;
	logic [WGT_W-1:0] wgt_edge;
	logic [WGT_W-1:0] wgt_corner;
	pix_t             line_a [MAXW];
	pix_t             line_b [MAXW];
	col_t             win [3];
	int unsigned      pix_taken;
	int unsigned      col_pos;
	int unsigned      res_given;

	function automatic int unsigned width_eff();
		if (frame_w_reg == 0)
			return 1;
		if (32'(frame_w_reg) > MAXW)
			return MAXW;
		return 32'(frame_w_reg);
	endfunction

	function automatic int unsigned height_eff();
		return (frame_h_reg == 0) ? 1 : 32'(frame_h_reg);
	endfunction

	task automatic frame_restart();
		pix_taken = 0;
		col_pos   = 0;
		res_given = 0;
		for (int i = 0; i < 3; i++)
			win[i] = '0;
	endtask

	function automatic pix_t blur_tap(col_t lft, col_t ctr, col_t rgt, int unsigned r,
		int unsigned c, int unsigned w, int unsigned h);
		int unsigned t;
		int unsigned b;
		col_t        l;
		col_t        g;
		logic [63:0] acc;
		// replicate the border row or column by reusing the center tap
		t = (r == 0) ? 1 : 0;
		b = (r + 1 >= h) ? 1 : 2;
		l = (c == 0) ? ctr : lft;
		g = (c + 1 >= w) ? ctr : rgt;
		acc = 64'(wgt_center) * 64'(ctr[1])
			+ 64'(wgt_edge) * (64'(ctr[t]) + 64'(ctr[b]) + 64'(l[1]) + 64'(g[1]))
			+ 64'(wgt_corner) * (64'(l[t]) + 64'(l[b]) + 64'(g[t]) + 64'(g[b]));
		acc = acc >> FRAC;
		return (acc > 64'(PIX_MAX)) ? PIX_MAX : acc[PIX_W-1:0];
	endfunction

	task automatic blur_predict(input cmd_t cmd, input pix_t pix);
		int unsigned w;
		int unsigned h;
		int unsigned total;
		int unsigned x;
		col_t        fresh;
		bit          emit;
		blur_res_t   r;
		w     = width_eff();
		h     = height_eff();
		total = w * h;
		if (cmd == CMD_PIXEL && pix_taken >= total)
			return;
		if (cmd == CMD_DRAIN && pix_taken < total)
			return;
		x = (col_pos >= w) ? 0 : col_pos;
		fresh[0] = line_b[x];
		fresh[1] = line_a[x];
		fresh[2] = (cmd == CMD_DRAIN) ? '0 : pix;
		line_b[x] = fresh[1];
		line_a[x] = fresh[2];
		emit = (pix_taken >= w + 1);
		r = '0;
		// at column zero the window still holds the previous row's last columns
		if (emit && x == 0)
			r.pixel_out = blur_tap(win[1], win[2], win[2], res_given / w, res_given % w, w, h);
		win[0] = win[1];
		win[1] = win[2];
		win[2] = fresh;
		if (emit && x != 0)
			r.pixel_out = blur_tap(win[0], win[1], win[2], res_given / w, res_given % w, w, h);
		pix_taken++;
		col_pos = (x + 1 >= w) ? 0 : x + 1;
		if (emit) begin
			res_given++;
			r.last_of_frame = (res_given >= total);
			if (r.last_of_frame)
				frame_restart();
			blurred_q.push_back(r);
		end
	endtask

	function automatic pix_t rand_pix();
		case ($urandom_range(7))
			0: return '0;
			1: return PIX_MAX;
			default: return pix_t'($urandom_range(255));
		endcase
	endfunction

	task automatic push_one(input cmd_t cmd, input pix_t pix);
		pixel_beats_q.push_back('{cmd: cmd, pix: pix});
	endtask

	task automatic push_pixels(input int unsigned n);
		repeat (n) push_one(CMD_PIXEL, rand_pix());
	endtask

	task automatic push_drains(input int unsigned n);
		repeat (n) push_one(CMD_DRAIN, pix_t'($urandom_range(255)));
	endtask

	task automatic wait_drained(input int unsigned extra);
		do
			@(negedge clk);
		while (pixel_beats_q.size() != 0 || pix_if.valid || blurred_q.size() != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH: begin
				frame_w_reg = val[FW_W-1:0];
				frame_restart();
			end
			REG_FRAME_HEIGHT: begin
				frame_h_reg = val[FH_W-1:0];
				frame_restart();
			end
			REG_WEIGHT_CENTER: wgt_center = val;
			REG_WEIGHT_EDGE:   wgt_edge   = val;
			REG_WEIGHT_CORNER: wgt_corner = val;
			default: ;
		endcase
	endtask

	task automatic set_weights(input logic [WGT_W-1:0] wc, input logic [WGT_W-1:0] we_,
		input logic [WGT_W-1:0] wk);
		cfg_write(REG_WEIGHT_CENTER, wc);
		cfg_write(REG_WEIGHT_EDGE, we_);
		cfg_write(REG_WEIGHT_CORNER, wk);
	endtask

	// one whole frame plus the w+1 drains that flush it; noisy adds a stray drain and pixel
	task automatic push_frame(input bit pause_mid, input bit noisy);
		int unsigned total;
		int unsigned half;
		total = width_eff() * height_eff();
		half  = $urandom_range(total);
		push_pixels(half);
		if (noisy)
			push_drains(1);
		if (pause_mid)
			wait_drained(0);
		push_pixels(total - half);
		if (noisy)
			push_one(CMD_PIXEL, rand_pix());
		push_drains(width_eff() + 1);
		random_beats += total + width_eff() + 1;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_if.valid    <= 1'b0;
			pix_if.cmd      <= CMD_PIXEL;
			pix_if.pixel_in <= '0;
		end else begin
			if (pix_if.valid && pix_if.ready)
				blur_predict(cmd_t'(pix_if.cmd), pix_if.pixel_in);
			if (!pix_if.valid || pix_if.ready) begin
				if (pixel_beats_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_beat = pixel_beats_q.pop_front();
					pix_if.valid    <= 1'b1;
					pix_if.cmd      <= drv_beat.cmd;
					pix_if.pixel_in <= drv_beat.pix;
				end else begin
					pix_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (blurred_q.size() == 0) begin
					$error("unexpected result beat: pixel_out=%0d last_of_frame=%0b",
						res_if.pixel_out, res_if.last_of_frame);
					mismatch_count++;
				end else begin
					want = blurred_q.pop_front();
					if (res_if.pixel_out !== want.pixel_out) begin
						$error("pixel_out: expected %0d, got %0d", want.pixel_out,
							res_if.pixel_out);
						mismatch_count++;
					end
					if (res_if.last_of_frame !== want.last_of_frame) begin
						$error("last_of_frame: expected %0b, got %0b", want.last_of_frame,
							res_if.last_of_frame);
						mismatch_count++;
					end
				end
			end
			res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		frame_w_reg = FRAME_WIDTH_RST;
		frame_h_reg = FRAME_HEIGHT_RST;
		wgt_center  = WEIGHT_CENTER_RST;
		wgt_edge    = WEIGHT_EDGE_RST;
		wgt_corner  = WEIGHT_CORNER_RST;
		for (int i = 0; i < MAXW; i++) begin
			line_a[i] = '0;
			line_b[i] = '0;
		end
		frame_restart();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// zero sizes act as a single pixel; stray drain and stray pixel are dropped
		cfg_write(REG_FRAME_WIDTH, 0);
		cfg_write(REG_FRAME_HEIGHT, 0);
		push_drains(1);
		push_one(CMD_PIXEL, PIX_MAX);
		push_one(CMD_PIXEL, '0);
		push_drains(2);
		wait_drained(DRAIN_LAT);

		// full-scale weights saturate wherever the full-scale pixel counts as two taps or more
		cfg_write(REG_FRAME_WIDTH, 3);
		cfg_write(REG_FRAME_HEIGHT, 2);
		set_weights('1, '1, '1);
		repeat (5) push_one(CMD_PIXEL, '0);
		push_one(CMD_PIXEL, PIX_MAX);
		push_drains(4);
		wait_drained(DRAIN_LAT);

		// single row: the first drain only advances the window
		cfg_write(REG_FRAME_WIDTH, 2);
		cfg_write(REG_FRAME_HEIGHT, 1);
		set_weights('0, '0, '0);
		push_one(CMD_PIXEL, PIX_MAX);
		push_one(CMD_PIXEL, PIX_MAX);
		push_drains(3);
		wait_drained(DRAIN_LAT);
		set_weights(WEIGHT_CENTER_RST, WEIGHT_EDGE_RST, WEIGHT_CORNER_RST);

		while (random_beats < RANDOM_BEATS) begin
			if (random_beats < RANDOM_BEATS / 3) begin
				send_idle_pct = 14;
				recv_idle_pct = 66;
			end else if (random_beats < 2 * RANDOM_BEATS / 3) begin
				send_idle_pct = 66;
				recv_idle_pct = 14;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case ($urandom_range(9))
				0: cfg_write(REG_FRAME_WIDTH, 0);
				1: cfg_write(REG_FRAME_WIDTH, CFG_W'($urandom_range(40, 13)));
				default: cfg_write(REG_FRAME_WIDTH, CFG_W'($urandom_range(10, 1)));
			endcase
			cfg_write(REG_FRAME_HEIGHT,
				($urandom_range(9) == 0) ? '0 : CFG_W'($urandom_range(6, 1)));
			case ($urandom_range(5))
				0: set_weights(WGT_W'($urandom_range(65535)), WGT_W'($urandom_range(65535)),
					WGT_W'($urandom_range(65535)));
				1: set_weights($urandom_range(1) ? '1 : '0, $urandom_range(1) ? '1 : '0,
					$urandom_range(1) ? '1 : '0);
				2: set_weights(WGT_W'($urandom_range(32767)), WGT_W'($urandom_range(8191)),
					WGT_W'($urandom_range(8191)));
				3: set_weights(WEIGHT_CENTER_RST, WEIGHT_EDGE_RST, WEIGHT_CORNER_RST);
				default: ;
			endcase
			if ($urandom_range(7) == 0) begin
				// partial frame, then a size write throws it away
				push_pixels($urandom_range(width_eff() * height_eff() - 1));
				wait_drained(DRAIN_LAT);
				cfg_write(REG_FRAME_HEIGHT, CFG_W'(frame_h_reg));
			end
			// back-to-back frames restart on their own after last_of_frame
			repeat ($urandom_range(3, 1))
				push_frame(random_beats == 0 || $urandom_range(7) == 0, $urandom_range(4) == 0);
			wait_drained(DRAIN_LAT);
		end

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
